// ----- src/coverage_triangle_rasterizer_unit_defines.svh -----
// assertion macros shared by the rasterizer rtl
// expects clk and arst_n in the scope of each use
`ifndef COVERAGE_TRIANGLE_RASTERIZER_UNIT_DEFINES_SVH
`define COVERAGE_TRIANGLE_RASTERIZER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define CTR_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define CTR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define CTR_ASSERT_IMPL(label, ante, cons, msg)

`define CTR_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ----- src/ctr_pkg.sv -----
// shared types, widths and codes of the coverage triangle rasterizer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ctr_pkg;

	localparam int MAX_PIXEL_DIM        = 256;
	localparam int HEIGHT_FRACTION_BITS = 8;

	localparam int CRD_W   = 15;
	localparam int HGT_W   = 24;
	localparam int DIM_W   = 9;
	localparam int CNT_W   = 17;
	localparam int PIX_W   = $clog2(MAX_PIXEL_DIM);
	localparam int MAP_AW  = 2 * PIX_W;
	localparam int MAP_DEPTH = 1 << MAP_AW;
	localparam int AB_W    = CRD_W + 1;
	localparam int PROD_W  = 2 * CRD_W;
	localparam int C_W     = PROD_W + 1;
	localparam int AREA_W  = C_W + 2;
	localparam int EDGE_W  = AREA_W + 1;
	localparam int DEN_W   = AREA_W - 1;
	localparam int NUM_W   = HGT_W + 1 + HEIGHT_FRACTION_BITS;
	localparam int HV_W    = NUM_W + 7;
	localparam int ITER_W  = $clog2(HV_W + 1);
	localparam int Q_DEPTH = 2;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic REG_PIXEL_WIDTH  = 1'b0;
	localparam logic REG_PIXEL_HEIGHT = 1'b1;

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_RASTER = 2'd1,
		OP_READ   = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		B_CLEAR,
		B_IDLE,
		B_PREP,
		B_MEMW,
		B_DIV,
		B_FIX,
		B_MUL,
		B_WALK,
		B_DRAIN,
		B_DONE
	} bstate_t;

	// one classified item as it crosses the queue
	typedef struct packed {
		op_t                       op;
		logic                      in_range;
		logic [PIX_W-1:0]          tx;
		logic [PIX_W-1:0]          ty;
		logic signed [HGT_W-1:0]   h0;
		logic signed [HGT_W-1:0]   h1;
		logic signed [HGT_W-1:0]   h2;
		logic signed [AB_W-1:0]    a0;
		logic signed [AB_W-1:0]    a1;
		logic signed [AB_W-1:0]    a2;
		logic signed [AB_W-1:0]    b0;
		logic signed [AB_W-1:0]    b1;
		logic signed [AB_W-1:0]    b2;
		logic signed [C_W-1:0]     c0;
		logic signed [C_W-1:0]     c1;
		logic signed [C_W-1:0]     c2;
		logic signed [AREA_W-1:0]  area;
		logic [2:0]                tl;
		logic [PIX_W-1:0]          minx;
		logic [PIX_W-1:0]          maxx;
		logic [PIX_W-1:0]          miny;
		logic [PIX_W-1:0]          maxy;
		logic                      culled;
	} cmd_t;

	typedef struct packed {
		logic init_clear;
		logic idle;
	} back_stat_t;

endpackage

`default_nettype wire

// ----- src/ctr_ram.sv -----
// generic single port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module ctr_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

`default_nettype wire

// ----- src/ctr_front.sv -----
// front: accepts items, forms edge terms and the clipped box, classifies
// depends on ctr_pkg
`timescale 1ns / 1ps
`default_nettype none

module ctr_front import ctr_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output      logic                    in_ready,
	input  wire logic [1:0]              operation,
	input  wire logic signed [CRD_W-1:0] vert0_x,
	input  wire logic signed [CRD_W-1:0] vert0_y,
	input  wire logic signed [HGT_W-1:0] vert0_height,
	input  wire logic signed [CRD_W-1:0] vert1_x,
	input  wire logic signed [CRD_W-1:0] vert1_y,
	input  wire logic signed [HGT_W-1:0] vert1_height,
	input  wire logic signed [CRD_W-1:0] vert2_x,
	input  wire logic signed [CRD_W-1:0] vert2_y,
	input  wire logic signed [HGT_W-1:0] vert2_height,
	input  wire logic [DIM_W-1:0]        w_eff,
	input  wire logic [DIM_W-1:0]        h_eff,
	input  wire logic                    hold,
	input  wire logic                    q_full,
	output      logic                    q_push,
	output      cmd_t                    q_entry
);

	localparam int EA [3] = '{1, 2, 0};
	localparam int EB [3] = '{2, 0, 1};

	logic s1_v_q, s2_v_q, s1_go, s2_go, accept;

	op_t                    op_s1;
	logic signed [CRD_W-1:0] x_s1 [3];
	logic signed [CRD_W-1:0] y_s1 [3];
	logic signed [HGT_W-1:0] h_s1 [3];

	op_t                     op_s2;
	logic signed [HGT_W-1:0] h_s2 [3];
	logic signed [AB_W-1:0]  a_s2 [3];
	logic signed [AB_W-1:0]  b_s2 [3];
	logic signed [PROD_W-1:0] p_s2 [3];
	logic signed [PROD_W-1:0] q_s2 [3];
	logic [2:0]              tl_s2;
	logic [PIX_W-1:0]        tx_s2, ty_s2, minx_s2, maxx_s2, miny_s2, maxy_s2;
	logic                    empty_s2, inr_s2;

	logic signed [AB_W-1:0]   a_c [3];
	logic signed [AB_W-1:0]   b_c [3];
	logic signed [PROD_W-1:0] p_c [3];
	logic signed [PROD_W-1:0] q_c [3];
	logic [2:0]               tl_c;
	logic signed [AB_W-1:0]   minx, maxx, miny, maxy, wx, hx, wm1, hm1, x0e, y0e;
	logic signed [AB_W-1:0]   minx_c, maxx_c, miny_c, maxy_c;
	logic                     empty_c, inr_c;
	logic signed [C_W-1:0]    c_c [3];
	logic signed [AREA_W-1:0] area_c;

	assign s2_go    = !s2_v_q || !q_full;
	assign s1_go    = !s1_v_q || s2_go;
	assign in_ready = s1_go && !hold;
	assign accept   = in_valid && in_ready;
	assign q_push   = s2_v_q && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
			s2_v_q <= 1'b0;
		end else begin
			if (s1_go) begin
				s1_v_q <= accept;
			end
			if (s2_go) begin
				s2_v_q <= s1_v_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= op_t'(operation);
			x_s1[0] <= vert0_x;
			y_s1[0] <= vert0_y;
			h_s1[0] <= vert0_height;
			x_s1[1] <= vert1_x;
			y_s1[1] <= vert1_y;
			h_s1[1] <= vert1_height;
			x_s1[2] <= vert2_x;
			y_s1[2] <= vert2_y;
			h_s1[2] <= vert2_height;
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			a_c[k]  = AB_W'(y_s1[EA[k]]) - AB_W'(y_s1[EB[k]]);
			b_c[k]  = AB_W'(x_s1[EB[k]]) - AB_W'(x_s1[EA[k]]);
			p_c[k]  = PROD_W'(x_s1[EA[k]]) * PROD_W'(y_s1[EB[k]]);
			q_c[k]  = PROD_W'(x_s1[EB[k]]) * PROD_W'(y_s1[EA[k]]);
			tl_c[k] = ((y_s1[EA[k]] == y_s1[EB[k]]) && (x_s1[EB[k]] > x_s1[EA[k]]))
				|| (y_s1[EB[k]] < y_s1[EA[k]]);
		end
		minx = AB_W'(x_s1[0]);
		maxx = AB_W'(x_s1[0]);
		miny = AB_W'(y_s1[0]);
		maxy = AB_W'(y_s1[0]);
		for (int k = 1; k < 3; k++) begin
			if (AB_W'(x_s1[k]) < minx) minx = AB_W'(x_s1[k]);
			if (AB_W'(x_s1[k]) > maxx) maxx = AB_W'(x_s1[k]);
			if (AB_W'(y_s1[k]) < miny) miny = AB_W'(y_s1[k]);
			if (AB_W'(y_s1[k]) > maxy) maxy = AB_W'(y_s1[k]);
		end
		wx     = AB_W'(w_eff);
		hx     = AB_W'(h_eff);
		wm1    = wx - AB_W'(1);
		hm1    = hx - AB_W'(1);
		minx_c = (minx < 0) ? '0 : minx;
		miny_c = (miny < 0) ? '0 : miny;
		maxx_c = (maxx > wm1) ? wm1 : maxx;
		maxy_c = (maxy > hm1) ? hm1 : maxy;
		empty_c = (maxx_c < minx_c) || (maxy_c < miny_c);
		x0e    = AB_W'(x_s1[0]);
		y0e    = AB_W'(y_s1[0]);
		inr_c  = (x0e >= 0) && (x0e < wx) && (y0e >= 0) && (y0e < hx);
	end

	always_ff @(posedge clk) begin
		if (s2_go && s1_v_q) begin
			op_s2    <= op_s1;
			h_s2     <= h_s1;
			a_s2     <= a_c;
			b_s2     <= b_c;
			p_s2     <= p_c;
			q_s2     <= q_c;
			tl_s2    <= tl_c;
			tx_s2    <= x_s1[0][PIX_W-1:0];
			ty_s2    <= y_s1[0][PIX_W-1:0];
			minx_s2  <= minx_c[PIX_W-1:0];
			maxx_s2  <= maxx_c[PIX_W-1:0];
			miny_s2  <= miny_c[PIX_W-1:0];
			maxy_s2  <= maxy_c[PIX_W-1:0];
			empty_s2 <= empty_c;
			inr_s2   <= inr_c;
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			c_c[k] = C_W'(p_s2[k]) - C_W'(q_s2[k]);
		end
		area_c = AREA_W'(c_c[0]) + AREA_W'(c_c[1]) + AREA_W'(c_c[2]);
		q_entry.op       = op_s2;
		q_entry.in_range = inr_s2;
		q_entry.tx       = tx_s2;
		q_entry.ty       = ty_s2;
		q_entry.h0       = h_s2[0];
		q_entry.h1       = h_s2[1];
		q_entry.h2       = h_s2[2];
		q_entry.a0       = a_s2[0];
		q_entry.a1       = a_s2[1];
		q_entry.a2       = a_s2[2];
		q_entry.b0       = b_s2[0];
		q_entry.b1       = b_s2[1];
		q_entry.b2       = b_s2[2];
		q_entry.c0       = c_c[0];
		q_entry.c1       = c_c[1];
		q_entry.c2       = c_c[2];
		q_entry.area     = area_c;
		q_entry.tl       = tl_s2;
		q_entry.minx     = minx_s2;
		q_entry.maxx     = maxx_s2;
		q_entry.miny     = miny_s2;
		q_entry.maxy     = maxy_s2;
		// zero or negative twice-area, or nothing left after clipping
		q_entry.culled   = (area_c <= 0) || empty_s2;
	end

endmodule

`default_nettype wire

// ----- src/ctr_queue.sv -----
// short fifo of classified items between front and back
// depends on ctr_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "coverage_triangle_rasterizer_unit_defines.svh"

module ctr_queue import ctr_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t wdata,
	output      logic full,
	input  wire logic pop,
	output      logic valid,
	output      cmd_t rdata
);

	localparam int PTR_W = $clog2(Q_DEPTH);

	cmd_t                 mem_q [Q_DEPTH];
	logic [PTR_W-1:0]     wp_q, rp_q;
	logic [PTR_W:0]       count_q;

	assign full  = (count_q == (PTR_W+1)'(Q_DEPTH));
	assign valid = (count_q != '0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wp_q + PTR_W'(1);
			end
			if (pop) begin
				rp_q <= (rp_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rp_q + PTR_W'(1);
			end
			count_q <= count_q + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
		end
	end

	`CTR_ASSERT_IMPL(a_q_no_overflow, full, !push, "queue written while full")
	`CTR_ASSERT_IMPL(a_q_no_underflow, pop, valid, "queue read while empty")

endmodule

`default_nettype wire

// ----- src/ctr_back.sv -----
// back: carries out load, read, clear and the triangle walk
// depends on ctr_pkg, ctr_ram and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "coverage_triangle_rasterizer_unit_defines.svh"

module ctr_back import ctr_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             q_valid,
	input  wire cmd_t             q_head,
	output      logic             q_pop,
	input  wire logic [DIM_W-1:0] w_eff,
	output      back_stat_t       stat,
	output      logic             out_valid,
	input  wire logic             out_ready,
	output      logic             coverage_bit,
	output      logic [CNT_W-1:0] pixels_set,
	output      logic             culled
);

	localparam int ML_W = AB_W + PIX_W + 1;
	localparam int TP_W = PIX_W + DIM_W;

	bstate_t state_q, state_d;
	cmd_t    cmd_q;

	logic                     reply_clr_q;
	logic [MAP_AW-1:0]        sweep_q;
	logic [ITER_W-1:0]        it_q;
	logic [1:0]               round_q;
	logic [DEN_W-1:0]         rem1_q, rem2_q;
	logic [NUM_W-1:0]         quo1_q, quo2_q;
	logic                     neg1_q, neg2_q;
	logic [HV_W-1:0]          f1_q, f2_q;
	logic [HV_W-1:0]          ma1_q, ma2_q, mb1_q, mb2_q, acc1_q, acc2_q;
	logic signed [EDGE_W-1:0] e_q [3];
	logic signed [EDGE_W-1:0] erow_q [3];
	logic [HV_W-1:0]          hv_q, hrow_q, dhx_q, dhy_q;
	logic [PIX_W-1:0]         px_q, py_q;
	logic [MAP_AW-1:0]        rbase_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     res_cov_q;
	logic                     v_s1;
	logic [MAP_AW-1:0]        idx_s1;
	logic [HV_W-1:0]          hv_s1;
	logic                     out_v_q, out_cov_q, out_cul_q;
	logic [CNT_W-1:0]         out_cnt_q;

	logic                     hgt_we, cov_we, cov_wd, cov_set, pass, out_load;
	logic [MAP_AW-1:0]        hgt_addr, cov_addr, taddr, idx;
	logic [HGT_W-1:0]         hgt_rdata;
	logic [0:0]               cov_rdata;
	logic [TP_W-1:0]          tprod, rprod;
	logic signed [AB_W-1:0]   ak [3];
	logic signed [AB_W-1:0]   bk [3];
	logic signed [EDGE_W-1:0] est [3];
	logic signed [NUM_W-1:0]  n1, n2;
	logic [DEN_W-1:0]         den;
	logic [DEN_W:0]           dv1, dv2;
	logic [HV_W-1:0]          fix1, fix2, acc1_n, acc2_n, hsum, hbase;
	logic signed [HV_W-1:0]   surf;

	function automatic logic signed [EDGE_W-1:0] edge_start(
		input logic signed [AB_W-1:0] a,
		input logic signed [AB_W-1:0] b,
		input logic signed [C_W-1:0]  c,
		input logic [PIX_W-1:0]       x,
		input logic [PIX_W-1:0]       y
	);
		logic signed [ML_W-1:0] ax, by;
		ax = ML_W'(a) * ML_W'($signed({1'b0, x}));
		by = ML_W'(b) * ML_W'($signed({1'b0, y}));
		return EDGE_W'(ax) + EDGE_W'(by) + EDGE_W'(c);
	endfunction

	// one restoring step: {remainder, quotient bit}
	function automatic logic [DEN_W:0] div_step(
		input logic [DEN_W-1:0] rem,
		input logic             nbit,
		input logic [DEN_W-1:0] d
	);
		logic [DEN_W:0] sh;
		logic [DEN_W:0] df;
		sh = {rem, nbit};
		df = sh - {1'b0, d};
		if (sh >= {1'b0, d}) begin
			return {df[DEN_W-1:0], 1'b1};
		end
		return {sh[DEN_W-1:0], 1'b0};
	endfunction

	// floor quotient from magnitude division
	function automatic logic [HV_W-1:0] floor_fix(
		input logic             neg,
		input logic [NUM_W-1:0] q,
		input logic [DEN_W-1:0] r
	);
		logic [HV_W-1:0] qe;
		qe = HV_W'(q);
		if (neg) begin
			return -(qe + HV_W'(r != '0));
		end
		return qe;
	endfunction

	assign ak[0] = cmd_q.a0;
	assign ak[1] = cmd_q.a1;
	assign ak[2] = cmd_q.a2;
	assign bk[0] = cmd_q.b0;
	assign bk[1] = cmd_q.b1;
	assign bk[2] = cmd_q.b2;

	always_comb begin
		est[0] = edge_start(cmd_q.a0, cmd_q.b0, cmd_q.c0, cmd_q.minx, cmd_q.miny);
		est[1] = edge_start(cmd_q.a1, cmd_q.b1, cmd_q.c1, cmd_q.minx, cmd_q.miny);
		est[2] = edge_start(cmd_q.a2, cmd_q.b2, cmd_q.c2, cmd_q.minx, cmd_q.miny);
		n1     = (NUM_W'(cmd_q.h1) - NUM_W'(cmd_q.h0)) <<< HEIGHT_FRACTION_BITS;
		n2     = (NUM_W'(cmd_q.h2) - NUM_W'(cmd_q.h0)) <<< HEIGHT_FRACTION_BITS;
		den    = cmd_q.area[DEN_W-1:0];
		dv1    = div_step(rem1_q, quo1_q[NUM_W-1], den);
		dv2    = div_step(rem2_q, quo2_q[NUM_W-1], den);
		fix1   = floor_fix(neg1_q, quo1_q, rem1_q);
		fix2   = floor_fix(neg2_q, quo2_q, rem2_q);
		acc1_n = acc1_q + (mb1_q[0] ? ma1_q : '0);
		acc2_n = acc2_q + (mb2_q[0] ? ma2_q : '0);
		hbase  = HV_W'(cmd_q.h0) << HEIGHT_FRACTION_BITS;
		hsum   = acc1_n + acc2_n;
		tprod  = cmd_q.ty * w_eff;
		rprod  = cmd_q.miny * w_eff;
		taddr  = MAP_AW'(tprod + TP_W'(cmd_q.tx));
		idx    = rbase_q + MAP_AW'(px_q);
		surf   = HV_W'($signed(hgt_rdata)) <<< HEIGHT_FRACTION_BITS;
		cov_set = v_s1 && ($signed(hv_s1) >= surf);
	end

	// inside test with the fill rule on the first zero edge only
	always_comb begin
		pass = (e_q[0] >= 0) && (e_q[1] >= 0) && (e_q[2] >= 0);
		if (e_q[0] == 0) begin
			pass = pass && cmd_q.tl[0];
		end else if (e_q[1] == 0) begin
			pass = pass && cmd_q.tl[1];
		end else if (e_q[2] == 0) begin
			pass = pass && cmd_q.tl[2];
		end
	end

	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		hgt_we   = 1'b0;
		hgt_addr = (state_q == B_WALK) ? idx : taddr;
		cov_we   = cov_set;
		cov_wd   = 1'b1;
		cov_addr = cov_set ? idx_s1 : taddr;
		out_load = 1'b0;
		case (state_q)
			B_CLEAR: begin
				cov_we   = 1'b1;
				cov_wd   = 1'b0;
				cov_addr = sweep_q;
				if (sweep_q == '1) begin
					state_d = reply_clr_q ? B_DONE : B_IDLE;
				end
			end
			B_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					state_d = B_PREP;
				end
			end
			B_PREP: begin
				case (cmd_q.op)
					OP_LOAD: begin
						hgt_we  = cmd_q.in_range;
						state_d = B_DONE;
					end
					OP_READ:   state_d = B_MEMW;
					OP_CLEAR:  state_d = B_CLEAR;
					OP_RASTER: state_d = cmd_q.culled ? B_DONE : B_DIV;
					default:   state_d = B_DONE;
				endcase
			end
			B_MEMW:  state_d = B_DONE;
			B_DIV: begin
				if (it_q == ITER_W'(NUM_W - 1)) begin
					state_d = B_FIX;
				end
			end
			B_FIX:   state_d = B_MUL;
			B_MUL: begin
				if ((it_q == ITER_W'(HV_W - 1)) && (round_q == 2'd2)) begin
					state_d = B_WALK;
				end
			end
			B_WALK: begin
				if ((px_q == cmd_q.maxx) && (py_q == cmd_q.maxy)) begin
					state_d = B_DRAIN;
				end
			end
			B_DRAIN: state_d = B_DONE;
			B_DONE: begin
				if (!out_v_q || out_ready) begin
					out_load = 1'b1;
					state_d  = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_CLEAR;
			reply_clr_q <= 1'b0;
			sweep_q     <= '0;
			v_s1        <= 1'b0;
			out_v_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= (state_q == B_WALK) && pass;
			if (state_q == B_CLEAR) begin
				sweep_q <= sweep_q + MAP_AW'(1);
			end
			if ((state_q == B_PREP) && (cmd_q.op == OP_CLEAR)) begin
				reply_clr_q <= 1'b1;
				sweep_q     <= '0;
			end
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx;
		hv_s1  <= hv_q;
		if (cov_set) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
		if (out_load) begin
			out_cov_q <= res_cov_q;
			out_cnt_q <= cnt_q;
			out_cul_q <= cmd_q.culled && (cmd_q.op == OP_RASTER);
		end
		case (state_q)
			B_IDLE: begin
				cmd_q     <= q_head;
				cnt_q     <= '0;
				res_cov_q <= 1'b0;
			end
			B_PREP: begin
				it_q    <= '0;
				neg1_q  <= n1[NUM_W-1];
				neg2_q  <= n2[NUM_W-1];
				quo1_q  <= n1[NUM_W-1] ? NUM_W'(-n1) : NUM_W'(n1);
				quo2_q  <= n2[NUM_W-1] ? NUM_W'(-n2) : NUM_W'(n2);
				rem1_q  <= '0;
				rem2_q  <= '0;
				e_q     <= est;
				erow_q  <= est;
				px_q    <= cmd_q.minx;
				py_q    <= cmd_q.miny;
				rbase_q <= MAP_AW'(rprod);
			end
			B_MEMW: begin
				res_cov_q <= cmd_q.in_range && cov_rdata[0];
			end
			B_DIV: begin
				it_q   <= it_q + ITER_W'(1);
				rem1_q <= dv1[DEN_W:1];
				rem2_q <= dv2[DEN_W:1];
				quo1_q <= {quo1_q[NUM_W-2:0], dv1[0]};
				quo2_q <= {quo2_q[NUM_W-2:0], dv2[0]};
			end
			B_FIX: begin
				f1_q    <= fix1;
				f2_q    <= fix2;
				ma1_q   <= fix1;
				ma2_q   <= fix2;
				mb1_q   <= HV_W'(e_q[1]);
				mb2_q   <= HV_W'(e_q[2]);
				acc1_q  <= '0;
				acc2_q  <= '0;
				it_q    <= '0;
				round_q <= 2'd0;
			end
			B_MUL: begin
				// shift-add products: f*e start, f*a, f*b in three rounds
				acc1_q <= acc1_n;
				acc2_q <= acc2_n;
				ma1_q  <= ma1_q << 1;
				ma2_q  <= ma2_q << 1;
				mb1_q  <= mb1_q >> 1;
				mb2_q  <= mb2_q >> 1;
				it_q   <= it_q + ITER_W'(1);
				if (it_q == ITER_W'(HV_W - 1)) begin
					case (round_q)
						2'd0: begin
							hv_q   <= hbase + hsum;
							hrow_q <= hbase + hsum;
						end
						2'd1:    dhx_q <= hsum;
						default: dhy_q <= hsum;
					endcase
					round_q <= round_q + 2'd1;
					it_q    <= '0;
					acc1_q  <= '0;
					acc2_q  <= '0;
					ma1_q   <= f1_q;
					ma2_q   <= f2_q;
					mb1_q   <= (round_q == 2'd0) ? HV_W'(ak[1]) : HV_W'(bk[1]);
					mb2_q   <= (round_q == 2'd0) ? HV_W'(ak[2]) : HV_W'(bk[2]);
				end
			end
			B_WALK: begin
				if (px_q == cmd_q.maxx) begin
					px_q    <= cmd_q.minx;
					py_q    <= py_q + PIX_W'(1);
					rbase_q <= rbase_q + MAP_AW'(w_eff);
					hrow_q  <= hrow_q + dhy_q;
					hv_q    <= hrow_q + dhy_q;
					for (int k = 0; k < 3; k++) begin
						erow_q[k] <= erow_q[k] + EDGE_W'(bk[k]);
						e_q[k]    <= erow_q[k] + EDGE_W'(bk[k]);
					end
				end else begin
					px_q <= px_q + PIX_W'(1);
					hv_q <= hv_q + dhx_q;
					for (int k = 0; k < 3; k++) begin
						e_q[k] <= e_q[k] + EDGE_W'(ak[k]);
					end
				end
			end
			default: begin
			end
		endcase
	end

	ctr_ram #(.WIDTH(HGT_W), .DEPTH(MAP_DEPTH)) u_hgt_ram (
		.clk   (clk),
		.we    (hgt_we),
		.addr  (hgt_addr),
		.wdata (cmd_q.h0),
		.rdata (hgt_rdata)
	);

	ctr_ram #(.WIDTH(1), .DEPTH(MAP_DEPTH)) u_cov_ram (
		.clk   (clk),
		.we    (cov_we),
		.addr  (cov_addr),
		.wdata (cov_wd),
		.rdata (cov_rdata)
	);

	assign stat.init_clear = (state_q == B_CLEAR) && !reply_clr_q;
	assign stat.idle       = (state_q == B_IDLE);
	assign out_valid       = out_v_q;
	assign coverage_bit    = out_cov_q;
	assign pixels_set      = out_cnt_q;
	assign culled          = out_cul_q;

	`CTR_ASSERT_IMPL(a_walk_in_box, state_q == B_WALK,
		px_q >= cmd_q.minx && px_q <= cmd_q.maxx && py_q >= cmd_q.miny && py_q <= cmd_q.maxy,
		"walk left the clipped box")
	`CTR_ASSERT_IMPL(a_cull_no_pix, out_v_q && out_cul_q, out_cnt_q == '0,
		"culled triangle reports pixels")
	`CTR_ASSERT_IMPL(a_set_in_walk, v_s1, state_q == B_WALK || state_q == B_DRAIN,
		"coverage set outside the walk")
	`CTR_ASSERT_NEXT(a_done_shows, state_q == B_DONE && (!out_v_q || out_ready), out_v_q,
		"finished item not presented")

endmodule

`default_nettype wire

// ----- src/coverage_triangle_rasterizer_unit.sv -----
// rasterize: 33-step divide, three 40-step shift-add rounds, then one box pixel a cycle on the
// height and coverage ram ports; a culled triangle skips the divide, the rounds and the walk
// throughput: one item at a time in the back end; the front and a 2-entry queue keep accepting while the queue has room
// reset: all control clears at once; a pass over every coverage address then zeroes it, no item accepted
// top level: config registers, front, queue and back; depends on ctr_pkg and the submodules
`timescale 1ns / 1ps
`default_nettype none

module coverage_triangle_rasterizer_unit import ctr_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    psel,
	input  wire logic                    penable,
	input  wire logic                    pwrite,
	input  wire logic [PADDR_W-1:0]      paddr,
	input  wire logic [PDATA_W-1:0]      pwdata,
	output      logic [PDATA_W-1:0]      prdata,
	output      logic                    pready,
	input  wire logic                    in_valid,
	output      logic                    in_ready,
	input  wire logic [1:0]              operation,
	input  wire logic signed [CRD_W-1:0] vert0_x,
	input  wire logic signed [CRD_W-1:0] vert0_y,
	input  wire logic signed [HGT_W-1:0] vert0_height,
	input  wire logic signed [CRD_W-1:0] vert1_x,
	input  wire logic signed [CRD_W-1:0] vert1_y,
	input  wire logic signed [HGT_W-1:0] vert1_height,
	input  wire logic signed [CRD_W-1:0] vert2_x,
	input  wire logic signed [CRD_W-1:0] vert2_y,
	input  wire logic signed [HGT_W-1:0] vert2_height,
	output      logic                    out_valid,
	input  wire logic                    out_ready,
	output      logic                    coverage_bit,
	output      logic [CNT_W-1:0]        pixels_set,
	output      logic                    culled
);

	logic [DIM_W-1:0] pw_q, ph_q, w_eff, h_eff;
	logic             q_push, q_full, q_pop, q_valid;
	cmd_t             q_in, q_head;
	back_stat_t       stat;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pw_q <= DIM_W'(256);
			ph_q <= DIM_W'(256);
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_PIXEL_WIDTH:  pw_q <= pwdata[DIM_W-1:0];
				REG_PIXEL_HEIGHT: ph_q <= pwdata[DIM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_PIXEL_WIDTH:  prdata = PDATA_W'(pw_q);
			REG_PIXEL_HEIGHT: prdata = PDATA_W'(ph_q);
			default:          prdata = '0;
		endcase
	end

	// sizes beyond the raster memory act as the largest size
	assign w_eff = (32'(pw_q) > MAX_PIXEL_DIM) ? DIM_W'(MAX_PIXEL_DIM) : pw_q;
	assign h_eff = (32'(ph_q) > MAX_PIXEL_DIM) ? DIM_W'(MAX_PIXEL_DIM) : ph_q;

	ctr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.vert0_x      (vert0_x),
		.vert0_y      (vert0_y),
		.vert0_height (vert0_height),
		.vert1_x      (vert1_x),
		.vert1_y      (vert1_y),
		.vert1_height (vert1_height),
		.vert2_x      (vert2_x),
		.vert2_y      (vert2_y),
		.vert2_height (vert2_height),
		.w_eff        (w_eff),
		.h_eff        (h_eff),
		.hold         (stat.init_clear),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_entry      (q_in)
	);

	ctr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_in),
		.full   (q_full),
		.pop    (q_pop),
		.valid  (q_valid),
		.rdata  (q_head)
	);

	ctr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_head       (q_head),
		.q_pop        (q_pop),
		.w_eff        (w_eff),
		.stat         (stat),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.coverage_bit (coverage_bit),
		.pixels_set   (pixels_set),
		.culled       (culled)
	);

endmodule

`default_nettype wire

// ----- sim/coverage_triangle_rasterizer_unit_checker.sv -----
// watches both channels and the register port of the rasterizer, predicts each result beat
// depends on ctr_pkg for widths, op codes and register indexes
`timescale 1ns / 1ps

module raster_result_checker import ctr_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic                    pready,
	input  logic [PADDR_W-1:0]      paddr,
	input  logic [PDATA_W-1:0]      pwdata,
	input  logic                    in_valid,
	input  logic                    in_ready,
	input  logic [1:0]              operation,
	input  logic signed [CRD_W-1:0] vert0_x,
	input  logic signed [CRD_W-1:0] vert0_y,
	input  logic signed [HGT_W-1:0] vert0_height,
	input  logic signed [CRD_W-1:0] vert1_x,
	input  logic signed [CRD_W-1:0] vert1_y,
	input  logic signed [HGT_W-1:0] vert1_height,
	input  logic signed [CRD_W-1:0] vert2_x,
	input  logic signed [CRD_W-1:0] vert2_y,
	input  logic signed [HGT_W-1:0] vert2_height,
	input  logic                    out_valid,
	input  logic                    out_ready,
	input  logic                    coverage_bit,
	input  logic [CNT_W-1:0]        pixels_set,
	input  logic                    culled,
	output int                      mismatches,
	output int                      pending
);

	typedef struct {
		bit             cov;
		bit [CNT_W-1:0] cnt;
		bit             cul;
	} raster_result_t;

	raster_result_t          expected_results[$];
	bit                      coverage_map[MAP_DEPTH];
	logic signed [HGT_W-1:0] surface_height[MAP_DEPTH];
	logic [DIM_W-1:0]        width_reg = 9'd256;
	logic [DIM_W-1:0]        height_reg = 9'd256;

	initial begin
		mismatches = 0;
		pending = 0;
	end

	function automatic longint dim_eff(logic [DIM_W-1:0] v);
		return (v > MAX_PIXEL_DIM) ? longint'(MAX_PIXEL_DIM) : longint'(v);
	endfunction

	function automatic longint floor_quot(longint n, longint d);
		longint q;
		q = n / d;
		if ((n % d) != 0 && n < 0)
			q--;
		return q;
	endfunction

	task automatic predict_coverage_result(input op_t op, input longint vx[3], input longint vy[3],
			input longint vh[3], output raster_result_t r);
		longint w, ht, idx, area, f1, f2, hv, scale;
		longint minx, maxx, miny, maxy;
		longint ea[3], eb[3], ec[3], e[3];
		bit tl[3];
		bit skip;
		int a, b;
		w = dim_eff(width_reg);
		ht = dim_eff(height_reg);
		r.cov = 0;
		r.cnt = '0;
		r.cul = 0;
		case (op)
			OP_LOAD, OP_READ: begin
				if (vx[0] >= 0 && vx[0] < w && vy[0] >= 0 && vy[0] < ht) begin
					idx = vy[0] * w + vx[0];
					if (op == OP_LOAD)
						surface_height[idx] = vh[0][HGT_W-1:0];
					else
						r.cov = coverage_map[idx];
				end
			end
			OP_CLEAR: begin
				coverage_map = '{default: 1'b0};
			end
			default: begin
				for (int k = 0; k < 3; k++) begin
					a = (k + 1) % 3;
					b = (k + 2) % 3;
					ea[k] = vy[a] - vy[b];
					eb[k] = vx[b] - vx[a];
					ec[k] = vx[a] * vy[b] - vx[b] * vy[a];
					tl[k] = (vy[a] == vy[b] && vx[b] > vx[a]) || (vy[b] < vy[a]);
				end
				area = ec[0] + ec[1] + ec[2];
				minx = vx[0]; maxx = vx[0]; miny = vy[0]; maxy = vy[0];
				for (int k = 1; k < 3; k++) begin
					if (vx[k] < minx) minx = vx[k];
					if (vx[k] > maxx) maxx = vx[k];
					if (vy[k] < miny) miny = vy[k];
					if (vy[k] > maxy) maxy = vy[k];
				end
				if (minx < 0) minx = 0;
				if (miny < 0) miny = 0;
				if (maxx > w - 1) maxx = w - 1;
				if (maxy > ht - 1) maxy = ht - 1;
				if (area <= 0 || maxx < minx || maxy < miny) begin
					r.cul = 1;
				end else begin
					scale = longint'(1) << HEIGHT_FRACTION_BITS;
					f1 = floor_quot((vh[1] - vh[0]) * scale, area);
					f2 = floor_quot((vh[2] - vh[0]) * scale, area);
					for (longint py = miny; py <= maxy; py++) begin
						for (longint px = minx; px <= maxx; px++) begin
							for (int k = 0; k < 3; k++)
								e[k] = ea[k] * px + eb[k] * py + ec[k];
							if (e[0] < 0 || e[1] < 0 || e[2] < 0)
								continue;
							// fill rule looks only at the first edge that passes through the pixel
							skip = 0;
							if (e[0] == 0) skip = !tl[0];
							else if (e[1] == 0) skip = !tl[1];
							else if (e[2] == 0) skip = !tl[2];
							if (skip)
								continue;
							idx = py * w + px;
							hv = vh[0] * scale + f1 * e[1] + f2 * e[2];
							if (hv >= longint'(surface_height[idx]) * scale) begin
								coverage_map[idx] = 1;
								r.cnt = r.cnt + 1'b1;
							end
						end
					end
				end
			end
		endcase
	endtask

	always @(posedge clk) begin : watch
		raster_result_t want;
		longint vx[3], vy[3], vh[3];
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("result beat with no expectation waiting");
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					if (coverage_bit !== want.cov) begin
						$error("coverage_bit expected %0d actual %0d", want.cov, coverage_bit);
						mismatches++;
					end
					if (pixels_set !== want.cnt) begin
						$error("pixels_set expected %0d actual %0d", want.cnt, pixels_set);
						mismatches++;
					end
					if (culled !== want.cul) begin
						$error("culled expected %0d actual %0d", want.cul, culled);
						mismatches++;
					end
				end
			end
			if (in_valid && in_ready) begin
				vx[0] = vert0_x; vy[0] = vert0_y; vh[0] = vert0_height;
				vx[1] = vert1_x; vy[1] = vert1_y; vh[1] = vert1_height;
				vx[2] = vert2_x; vy[2] = vert2_y; vh[2] = vert2_height;
				predict_coverage_result(op_t'(operation), vx, vy, vh, want);
				expected_results.push_back(want);
			end
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_PIXEL_WIDTH)
					width_reg = pwdata[DIM_W-1:0];
				else
					height_reg = pwdata[DIM_W-1:0];
			end
			pending = expected_results.size();
		end
	end

endmodule

// ----- sim/testbench.sv -----
// stimulus and verdict for the coverage triangle rasterizer unit
// depends on ctr_pkg, the rtl top and raster_result_checker
`timescale 1ns / 1ps

module testbench import ctr_pkg::*;;

	localparam int QUIET_LIMIT = 250000;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    psel = 1'b0;
	logic                    penable = 1'b0;
	logic                    pwrite = 1'b0;
	logic [PADDR_W-1:0]      paddr = '0;
	logic [PDATA_W-1:0]      pwdata = '0;
	logic [PDATA_W-1:0]      prdata;
	logic                    pready;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic [1:0]              operation = OP_READ;
	logic signed [CRD_W-1:0] vert0_x = '0;
	logic signed [CRD_W-1:0] vert0_y = '0;
	logic signed [HGT_W-1:0] vert0_height = '0;
	logic signed [CRD_W-1:0] vert1_x = '0;
	logic signed [CRD_W-1:0] vert1_y = '0;
	logic signed [HGT_W-1:0] vert1_height = '0;
	logic signed [CRD_W-1:0] vert2_x = '0;
	logic signed [CRD_W-1:0] vert2_y = '0;
	logic signed [HGT_W-1:0] vert2_height = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic                    coverage_bit;
	logic [CNT_W-1:0]        pixels_set;
	logic                    culled;
	int                      mismatches;
	int                      pending;

	int send_idle = 0;
	int recv_stall = 0;
	int hold_reqs = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int quiet = 0;
	int items_sent = 0;
	int cur_w = 256;
	int cur_h = 256;
	bit height_loaded[MAP_DEPTH];

	coverage_triangle_rasterizer_unit dut (.*);

	raster_result_checker u_checker (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: random stalls, plus a long hold-off when asked
	always @(posedge clk) begin
		if (hold_reqs != hold_seen) begin
			hold_seen = hold_reqs;
			hold_left = 600;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("coverage_triangle_rasterizer_unit verification failed");
				$finish;
			end
		end
	end

	task automatic send_item(input op_t op, input int x0, input int y0, input int h0,
			input int x1, input int y1, input int h1, input int x2, input int y2, input int h2);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		vert0_x <= x0; vert0_y <= y0; vert0_height <= h0;
		vert1_x <= x1; vert1_y <= y1; vert1_height <= h1;
		vert2_x <= x2; vert2_y <= y2; vert2_height <= h2;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
		if (op == OP_LOAD && x0 >= 0 && x0 < cur_w && y0 >= 0 && y0 < cur_h)
			height_loaded[y0 * cur_w + x0] = 1;
	endtask

	function automatic int surface_sample();
		return $urandom_range(4000) - 2000;
	endfunction

	function automatic int full_height();
		return int'($urandom_range(24'hFFFFFF)) - 8388608;
	endfunction

	function automatic int full_coord();
		return int'($urandom_range(32767)) - 16384;
	endfunction

	// every pixel the walk may test needs a loaded surface sample first
	task automatic raster(input int x0, input int y0, input int h0, input int x1, input int y1,
			input int h1, input int x2, input int y2, input int h2);
		int minx, maxx, miny, maxy;
		minx = x0 < x1 ? x0 : x1; minx = x2 < minx ? x2 : minx;
		maxx = x0 > x1 ? x0 : x1; maxx = x2 > maxx ? x2 : maxx;
		miny = y0 < y1 ? y0 : y1; miny = y2 < miny ? y2 : miny;
		maxy = y0 > y1 ? y0 : y1; maxy = y2 > maxy ? y2 : maxy;
		if (minx < 0) minx = 0;
		if (miny < 0) miny = 0;
		if (maxx > cur_w - 1) maxx = cur_w - 1;
		if (maxy > cur_h - 1) maxy = cur_h - 1;
		for (int py = miny; py <= maxy; py++)
			for (int px = minx; px <= maxx; px++)
				if (!height_loaded[py * cur_w + px])
					send_item(OP_LOAD, px, py, surface_sample(), full_coord(), full_coord(),
						full_height(), full_coord(), full_coord(), full_height());
		send_item(OP_RASTER, x0, y0, h0, x1, y1, h1, x2, y2, h2);
	endtask

	task automatic apb_write(input logic reg_index, input int value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_index, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_dims(input int w, input int h);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		apb_write(REG_PIXEL_WIDTH, w);
		apb_write(REG_PIXEL_HEIGHT, h);
		cur_w = w > MAX_PIXEL_DIM ? MAX_PIXEL_DIM : (w & 'h1FF);
		cur_h = h > MAX_PIXEL_DIM ? MAX_PIXEL_DIM : (h & 'h1FF);
	endtask

	task automatic random_item();
		int sel, bx, by, c[6], hv[3];
		sel = $urandom_range(999);
		for (int k = 0; k < 3; k++)
			hv[k] = ($urandom_range(99) < 80) ? int'($urandom_range(6000)) - 3000 : full_height();
		if (cur_w * cur_h <= 400) begin
			for (int k = 0; k < 6; k++)
				c[k] = ($urandom_range(99) < 10) ? full_coord() :
					int'($urandom_range((k % 2 ? cur_h : cur_w) + 5)) - 3;
		end else begin
			// large raster: keep boxes small around a random spot
			bx = $urandom_range(cur_w - 1);
			by = $urandom_range(cur_h - 1);
			for (int k = 0; k < 3; k++) begin
				c[2*k] = bx + int'($urandom_range(20)) - 10;
				c[2*k+1] = by + int'($urandom_range(20)) - 10;
			end
		end
		if (sel < 5)
			send_item(OP_CLEAR, full_coord(), full_coord(), full_height(), full_coord(),
				full_coord(), full_height(), full_coord(), full_coord(), full_height());
		else if (sel < 500)
			raster(c[0], c[1], hv[0], c[2], c[3], hv[1], c[4], c[5], hv[2]);
		else if (sel < 780)
			send_item(OP_READ, $urandom_range(99) < 85 ? int'($urandom_range(cur_w)) : full_coord(),
				$urandom_range(99) < 85 ? int'($urandom_range(cur_h)) : full_coord(),
				full_height(), full_coord(), full_coord(), full_height(),
				full_coord(), full_coord(), full_height());
		else
			send_item(OP_LOAD, $urandom_range(99) < 85 ? int'($urandom_range(cur_w)) : full_coord(),
				$urandom_range(99) < 85 ? int'($urandom_range(cur_h)) : full_coord(),
				$urandom_range(99) < 70 ? surface_sample() : full_height(),
				full_coord(), full_coord(), full_height(), full_coord(), full_coord(), full_height());
	endtask

	initial begin
		int dims_w[8] = '{256, 1, 16, 0, 511, 12, 5, 9};
		int dims_h[8] = '{256, 1, 16, 7, 3, 9, 511, 14};
		int target;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: corners, out of range targets, fill rule edges, culling, clear
		send_item(OP_LOAD, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		send_item(OP_LOAD, 255, 255, 8388607, 0, 0, 0, 0, 0, 0);
		send_item(OP_LOAD, -1, 0, 5, 0, 0, 0, 0, 0, 0);
		send_item(OP_LOAD, 256, 5, 5, 0, 0, 0, 0, 0, 0);
		send_item(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		send_item(OP_READ, 256, 256, 0, 0, 0, 0, 0, 0, 0);
		raster(0, 0, 100, 4, 0, 100, 0, 4, 100);
		raster(0, 0, 100, 0, 4, 100, 4, 0, 100);
		raster(0, 0, 0, 2, 2, 0, 4, 4, 0);
		raster(-10, -10, 0, -5, -10, 0, -10, -5, 0);
		raster(250, 250, -8388608, 255, 250, 8388607, 250, 255, 0);
		raster(2, 1, -500, 6, 5, 500, 1, 6, 0);
		send_item(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		send_item(OP_READ, 255, 255, 0, 0, 0, 0, 0, 0, 0);
		send_item(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		send_item(OP_READ, 1, 1, 0, 0, 0, 0, 0, 0, 0);
		set_dims(4, 3);
		raster(-16384, -16384, 8388607, 16383, -16384, 8388607, -16384, 16383, 8388607);
		raster(-16384, -16384, -8388608, -16384, 16383, 0, 16383, -16384, 0);
		raster(16383, 16383, 0, -16384, 16383, 0, 16383, -16384, -8388608);
		send_item(OP_READ, 3, 2, 0, 0, 0, 0, 0, 0, 0);
		send_item(OP_LOAD, 16383, -16384, -8388608, 0, 0, 0, 0, 0, 0);
		send_item(OP_READ, -16384, 16383, 0, 0, 0, 0, 0, 0, 0);

		for (int p = 0; p < 8; p++) begin
			set_dims(dims_w[p], dims_h[p]);
			case (p % 4)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 76; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 76; end
				default: begin send_idle = 35; recv_stall = 35; end
			endcase
			if (p == 4)
				hold_reqs++;
			target = items_sent + 135;
			while (items_sent < target)
				random_item();
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("covered %0d items: loads, reads, clears and triangles over eight raster sizes,",
			items_sent);
		$display("including zero and oversized dimensions, four idle mixes and a long output stall");
		if (mismatches == 0)
			$display("coverage_triangle_rasterizer_unit verification clean");
		else
			$display("coverage_triangle_rasterizer_unit verification failed");
		$finish;
	end

endmodule

// ----- coverage_triangle_rasterizer_unit.f -----
+incdir+src
src/ctr_pkg.sv
src/ctr_ram.sv
src/ctr_front.sv
src/ctr_queue.sv
src/ctr_back.sv
src/coverage_triangle_rasterizer_unit.sv
sim/coverage_triangle_rasterizer_unit_checker.sv
sim/testbench.sv
